FILE: rtl/core/tach_pkg.sv
// shared types and constants for the tachometer rpm core
`timescale 1ns / 1ps

package tach_pkg;

   localparam int COUNTER_WIDTH_DEFAULT = 16;
   localparam int CAPTURE_W = 16;
   localparam int PERIOD_OUT_W = 16;
   localparam int RPM_W = 26;
   localparam int THRESH_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   // one minute in 1 MHz ticks, the dividend of every speed calculation
   localparam logic [RPM_W-1:0] USEC_PER_MINUTE = RPM_W'(60000000);

   // restoring divide retires one quotient bit a cycle
   localparam int DIV_STEPS = RPM_W;
   localparam int STEP_W = $clog2(DIV_STEPS);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WARNING_RPM = 2'd0,
      CSR_ALARM_RPM   = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      LEVEL_NONE    = 2'd0,
      LEVEL_WARNING = 2'd1,
      LEVEL_ALARM   = 2'd2
   } level_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_CLASSIFY,
      BACK_RESULT
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: rtl/core/tach_front.sv
// front end: takes capture transfers and forms the period against the previous capture
`timescale 1ns / 1ps

module tach_front
   import tach_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CAPTURE_W-1:0]     req_capture_time,
   input  queue_status_type         queue_status,
   output logic                     push,
   output logic [COUNTER_WIDTH-1:0] push_period
);

   logic [COUNTER_WIDTH-1:0] prev_capture_ff;
   logic [COUNTER_WIDTH-1:0] prev_capture_in;
   logic [31:0]              capture_ext;
   logic [COUNTER_WIDTH-1:0] now;

   // capture folded into the counter width
   assign capture_ext = 32'(req_capture_time);
   assign now         = capture_ext[COUNTER_WIDTH-1:0];

   assign req_stall   = queue_status.full;
   assign push        = req_valid && !queue_status.full;
   assign push_period = now - prev_capture_ff;

   assign prev_capture_in = push ? now : prev_capture_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_capture_ff <= '0;
      end else begin
         prev_capture_ff <= prev_capture_in;
      end
   end

endmodule

FILE: rtl/core/tach_queue.sv
// short period queue between front and back ends
`timescale 1ns / 1ps

module tach_queue
   import tach_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [COUNTER_WIDTH-1:0] push_period,
   input  logic                     pop,
   output logic [COUNTER_WIDTH-1:0] head_period,
   output queue_status_type         queue_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [COUNTER_WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   assign queue_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign head_period        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_period;
      end
   end

endmodule

FILE: rtl/core/tach_back.sv
// back end: iterative divide of one minute by the period, level classification, result register
`timescale 1ns / 1ps

module tach_back
   import tach_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  queue_status_type         queue_status,
   input  logic [COUNTER_WIDTH-1:0] head_period,
   output logic                     pop,
   input  logic [THRESH_W-1:0]      warning_rpm,
   input  logic [THRESH_W-1:0]      alarm_rpm,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [PERIOD_OUT_W-1:0]  rsp_period_ticks,
   output logic [RPM_W-1:0]         rsp_rpm,
   output logic [1:0]               rsp_alarm_level
);

   back_state_type state_ff, state_in;

   logic [COUNTER_WIDTH-1:0] period_ff, period_in;
   logic [COUNTER_WIDTH-1:0] rem_ff, rem_in;
   logic [RPM_W-1:0]         quo_ff, quo_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [RPM_W-1:0]         last_rpm_ff, last_rpm_in;
   level_type                level_ff, level_in;

   logic [COUNTER_WIDTH:0]   trial;
   logic [COUNTER_WIDTH:0]   diff;
   logic                     fits;
   logic [RPM_W-1:0]         quo_step;
   logic                     last_step;
   logic                     zero_period;
   logic [31:0]              period_ext;

   // one restoring step: dividend bit from the top of quo, quotient bit into the bottom
   assign trial     = {rem_ff, quo_ff[RPM_W-1]};
   assign diff      = trial - {1'b0, period_ff};
   assign fits      = !diff[COUNTER_WIDTH];
   assign quo_step  = {quo_ff[RPM_W-2:0], fits};
   assign last_step = (step_ff == STEP_W'(DIV_STEPS - 1));

   assign zero_period = (head_period == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!queue_status.empty) begin
               state_in = zero_period ? BACK_RESULT : BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            if (last_step) begin
               state_in = BACK_CLASSIFY;
            end
         end
         BACK_CLASSIFY: begin
            state_in = BACK_RESULT;
         end
         BACK_RESULT: begin
            if (!rsp_stall) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      pop       = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         BACK_IDLE:   pop       = !queue_status.empty;
         BACK_RESULT: rsp_valid = 1'b1;
         default: begin
            pop       = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      period_in   = period_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      step_in     = step_ff;
      last_rpm_in = last_rpm_ff;
      level_in    = level_ff;
      case (state_ff)
         BACK_IDLE: begin
            period_in = head_period;
            rem_in    = '0;
            quo_in    = USEC_PER_MINUTE;
            step_in   = '0;
            level_in  = LEVEL_NONE;
         end
         BACK_DIVIDE: begin
            rem_in  = fits ? diff[COUNTER_WIDTH-1:0] : trial[COUNTER_WIDTH-1:0];
            quo_in  = quo_step;
            step_in = step_ff + 1'b1;
            if (last_step) begin
               last_rpm_in = quo_step;
            end
         end
         BACK_CLASSIFY: begin
            if (last_rpm_ff >= RPM_W'(alarm_rpm)) begin
               level_in = LEVEL_ALARM;
            end else if (last_rpm_ff >= RPM_W'(warning_rpm)) begin
               level_in = LEVEL_WARNING;
            end else begin
               level_in = LEVEL_NONE;
            end
         end
         default: begin
            level_in = level_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BACK_IDLE;
         last_rpm_ff <= '0;
      end else begin
         state_ff    <= state_in;
         last_rpm_ff <= last_rpm_in;
      end
   end

   always_ff @(posedge clock) begin
      period_ff <= period_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      level_ff  <= level_in;
   end

   always_comb begin
      period_ext                    = '0;
      period_ext[COUNTER_WIDTH-1:0] = period_ff;
   end

   assign rsp_period_ticks = period_ext[PERIOD_OUT_W-1:0];
   assign rsp_rpm          = last_rpm_ff;
   assign rsp_alarm_level  = level_ff;

endmodule

FILE: rtl/core/tach_rpm_with_alarm_levels_core.sv
// top level of the tachometer period to rpm core with alarm levels
`timescale 1ns / 1ps

//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  req     | in        | req_valid/req_stall | capture_time
//  rsp     | out       | rsp_valid/rsp_stall | period_ticks, rpm, alarm_level
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
//  an edge with a nonzero period goes through the back end in order: the pop, the
//  bit-a-cycle restoring divide of 60e6 by the period, the classify step and the
//  result stage; a zero period goes from the pop straight to the result stage
//  synchronous active-high reset: previous capture and held rpm go to zero,
//  both thresholds to 65535, queue and back end to empty and idle
//  req_stall rises only when the two-entry period queue is full; rsp_stall holds
//  the result register and the back end, the front keeps filling the queue

module tach_rpm_with_alarm_levels_core
   import tach_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   // input channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CAPTURE_W-1:0]    req_capture_time,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PERIOD_OUT_W-1:0] rsp_period_ticks,
   output logic [RPM_W-1:0]        rsp_rpm,
   output logic [1:0]              rsp_alarm_level,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [THRESH_W-1:0]     csr_wdata
);

   // threshold registers
   logic [THRESH_W-1:0] warning_rpm_ff, warning_rpm_in;
   logic [THRESH_W-1:0] alarm_rpm_ff, alarm_rpm_in;
   logic                csr_write;

   // front to queue
   logic                     push;
   logic [COUNTER_WIDTH-1:0] push_period;

   // queue to back
   logic                     pop;
   logic [COUNTER_WIDTH-1:0] head_period;
   queue_status_type         queue_status;

   // writes are always taken; unknown indices are dropped
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      warning_rpm_in = warning_rpm_ff;
      alarm_rpm_in   = alarm_rpm_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WARNING_RPM: warning_rpm_in = csr_wdata;
            CSR_ALARM_RPM:   alarm_rpm_in   = csr_wdata;
            default: begin
               warning_rpm_in = warning_rpm_ff;
               alarm_rpm_in   = alarm_rpm_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warning_rpm_ff <= '1;
         alarm_rpm_ff   <= '1;
      end else begin
         warning_rpm_ff <= warning_rpm_in;
         alarm_rpm_ff   <= alarm_rpm_in;
      end
   end

   // period from successive captures, modulo the counter width
   tach_front #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_capture_time(req_capture_time),
      .queue_status    (queue_status),
      .push            (push),
      .push_period     (push_period)
   );

   // decouples edge intake from the long divide
   tach_queue #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_period (push_period),
      .pop         (pop),
      .head_period (head_period),
      .queue_status(queue_status)
   );

   // divide, hold last speed on a zero period, classify against thresholds
   tach_back #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_status    (queue_status),
      .head_period     (head_period),
      .pop             (pop),
      .warning_rpm     (warning_rpm_ff),
      .alarm_rpm       (alarm_rpm_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_period_ticks(rsp_period_ticks),
      .rsp_rpm         (rsp_rpm),
      .rsp_alarm_level (rsp_alarm_level)
   );

endmodule
